// File: hdl/box_mean_filter_8x8_assert.svh
// Assertion macros used by the box mean filter top level.
`ifndef BOX_MEAN_FILTER_8X8_ASSERT_SVH
`define BOX_MEAN_FILTER_8X8_ASSERT_SVH
`ifndef SYNTHESIS
`define BMF8_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box mean filter: implication check failed");
`define BMF8_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box mean filter: next-cycle check failed");
`else
`define BMF8_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BMF8_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/bmf8_pkg.sv
// Types, constants and helpers shared by the box mean filter modules.
`timescale 1ns / 1ps
package bmf8_pkg;
    localparam int CH_W      = 8;
    localparam int COORD_W   = 10;
    localparam int CFG_W     = 11;
    localparam int SUM_W     = 14;
    localparam int TAP_W     = 6;
    localparam int MIN_SIZE  = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd480;
    localparam logic [TAP_W-1:0] LAST_TAP = 6'd63;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_TAIL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             accept;
        logic             issue;
        logic [TAP_W-1:0] tap;
        logic             load_out;
        logic             step_out;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic last_out;
        logic out_free;
    } t_sts;

    // Mean of a 64-entry window sum, (sum + 1) divided by 64 and truncated, limited to the channel range.
    function automatic logic [CH_W-1:0] mean_of(input logic [SUM_W-1:0] sum);
        logic [SUM_W:0]   s1;
        logic [SUM_W-6:0] q;
        s1 = {1'b0, sum} + {{SUM_W{1'b0}}, 1'b1};
        q  = s1[SUM_W:6];
        mean_of = (q > 9'd255) ? 8'd255 : q[CH_W-1:0];
    endfunction
endpackage

// File: hdl/bmf8_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module bmf8_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/bmf8_ctrl.sv
// Sequencer: per result, walks the 64 window taps and hands the sum to the output register.
`timescale 1ns / 1ps
module bmf8_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  bmf8_pkg::t_sts i_sts,
    output bmf8_pkg::t_cmd o_cmd
);
    import bmf8_pkg::*;

    t_state             r_state, n_state;
    logic [TAP_W-1:0]   r_tap, n_tap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    always_comb begin
        n_state = r_state;
        n_tap   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid && i_sts.emit) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_tap = r_tap + 1'b1;
                if (r_tap == LAST_TAP) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.last_out ? S_IDLE : S_RUN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready       = 1'b0;
        o_cmd           = '0;
        o_cmd.tap       = r_tap;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready    = 1'b1;
                o_cmd.accept = i_s_valid;
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
            end
            S_TAIL: begin
                o_cmd.issue = 1'b0;
            end
            S_EMIT: begin
                o_cmd.load_out = i_sts.out_free;
                o_cmd.step_out = i_sts.out_free && !i_sts.last_out;
            end
            default: o_s_ready = 1'b0;
        endcase
    end
endmodule

// File: hdl/bmf8_dp.sv
// Datapath: position counters, row ring, window addressing, sums and the output register.
`timescale 1ns / 1ps
module bmf8_dp #(
    parameter int MAX_WIDTH  = bmf8_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmf8_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cnt_clr,
    input  logic [bmf8_pkg::CFG_W-1:0]  i_frame_width,
    input  logic [bmf8_pkg::CFG_W-1:0]  i_frame_height,
    input  logic [3*bmf8_pkg::CH_W-1:0] i_pixel,
    input  bmf8_pkg::t_cmd              i_cmd,
    output bmf8_pkg::t_sts              o_sts,
    input  logic                        i_m_ready,
    output logic                        o_m_valid,
    output logic [47:0]                 o_m_data,
    output logic                        o_m_last
);
    import bmf8_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = 8 << XW;
    localparam int AW    = $clog2(DEPTH);

    logic [31:0]   w32, h32;
    logic [XW-1:0] wm1;
    logic [YW-1:0] hm1;
    logic [XW-1:0] r_px, r_ox, r_xlo, r_xhi;
    logic [YW-1:0] r_py, r_oy, r_yhi;
    logic [XW-1:0] xlo, xhi;
    logic [YW-1:0] ylo, yhi;
    logic signed [3:0]    di, dj;
    logic signed [YW+1:0] ys;
    logic signed [XW+1:0] xs;
    logic [YW-1:0] yy;
    logic [XW-1:0] xx;
    logic [AW-1:0] waddr, raddr;
    logic [3*CH_W-1:0] rdata;
    logic          r_rd_vld, r_rd_first;
    logic [SUM_W-1:0] r_sb, r_sg, r_sr;
    logic          r_out_valid;
    logic [CH_W-1:0] r_ob, r_og, r_or;
    logic [COORD_W-1:0] r_ocol, r_orow;
    logic          r_olast;
    logic [XW+COORD_W-1:0] col_ext;
    logic [YW+COORD_W-1:0] row_ext;

    // Frame size in use, held to the supported range.
    always_comb begin
        w32 = {21'b0, i_frame_width};
        h32 = {21'b0, i_frame_height};
        if (w32 < MIN_SIZE) w32 = MIN_SIZE;
        else if (w32 > MAX_WIDTH) w32 = MAX_WIDTH;
        if (h32 < MIN_SIZE) h32 = MIN_SIZE;
        else if (h32 > MAX_HEIGHT) h32 = MAX_HEIGHT;
        w32 = w32 - 32'd1;
        h32 = h32 - 32'd1;
        wm1 = w32[XW-1:0];
        hm1 = h32[YW-1:0];
    end

    assign xlo = r_px - XW'(3);
    assign xhi = (r_px == wm1) ? r_px : xlo;
    assign ylo = r_py - YW'(3);
    assign yhi = (r_py == hm1) ? r_py : ylo;
    assign o_sts.emit = (r_px >= XW'(3) || r_px == wm1) && (r_py >= YW'(3) || r_py == hm1);
    assign o_sts.last_out = (r_ox == r_xhi) && (r_oy == r_yhi);
    assign o_sts.out_free = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
        end else if (i_cnt_clr) begin
            r_px <= '0;
            r_py <= '0;
        end else if (i_cmd.accept) begin
            if (r_px == wm1) begin
                r_px <= '0;
                r_py <= (r_py == hm1) ? '0 : r_py + 1'b1;
            end else begin
                r_px <= r_px + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_xlo <= xlo;
            r_xhi <= xhi;
            r_yhi <= yhi;
            r_ox  <= xlo;
            r_oy  <= ylo;
        end else if (i_cmd.step_out) begin
            if (r_ox == r_xhi) begin
                r_ox <= r_xlo;
                r_oy <= r_oy + 1'b1;
            end else begin
                r_ox <= r_ox + 1'b1;
            end
        end
    end

    // Tap offsets run from -4 to +3 in both directions; rows first.
    always_comb begin
        di = $signed({1'b0, i_cmd.tap[5:3]}) - 4'sd4;
        dj = $signed({1'b0, i_cmd.tap[2:0]}) - 4'sd4;
        ys = $signed({2'b00, r_oy}) + (YW+2)'(di);
        xs = $signed({2'b00, r_ox}) + (XW+2)'(dj);
        if (ys < 0) yy = '0;
        else if (ys > $signed({2'b00, hm1})) yy = hm1;
        else yy = ys[YW-1:0];
        if (xs < 0) xx = '0;
        else if (xs > $signed({2'b00, wm1})) xx = wm1;
        else xx = xs[XW-1:0];
    end

    assign waddr = {r_py[2:0], r_px};
    assign raddr = {yy[2:0], xx};

    bmf8_ram #(
        .WIDTH (3*CH_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (waddr),
        .i_wdata (i_pixel),
        .i_re    (i_cmd.issue),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.issue;
            r_rd_first <= i_cmd.issue && (i_cmd.tap == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_sb <= (r_rd_first ? '0 : r_sb) + SUM_W'(rdata[7:0]);
            r_sg <= (r_rd_first ? '0 : r_sg) + SUM_W'(rdata[15:8]);
            r_sr <= (r_rd_first ? '0 : r_sr) + SUM_W'(rdata[23:16]);
        end
    end

    assign col_ext = {{COORD_W{1'b0}}, r_ox};
    assign row_ext = {{COORD_W{1'b0}}, r_oy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_ob    <= mean_of(r_sb);
            r_og    <= mean_of(r_sg);
            r_or    <= mean_of(r_sr);
            r_ocol  <= col_ext[COORD_W-1:0];
            r_orow  <= row_ext[COORD_W-1:0];
            r_olast <= o_sts.last_out;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = {4'b0, r_orow, r_ocol, r_or, r_og, r_ob};
    assign o_m_last  = r_olast;
endmodule

// File: hdl/box_mean_filter_8x8.sv
// Streaming 8x8 box mean filter on BGR pixels: top level.
// Pixels enter on the s_ stream in raster order, one beat per pixel, with
// blue, green and red in s_tdata. Results leave on the m_ stream, each beat
// carrying the three filtered channels and the output column and row; m_tlast
// marks the last result that a given input pixel releases. Pixels in the first
// three columns or rows release nothing, interior pixels one result, row ends
// and the last row four, and the final pixel of a frame sixteen.
// A pixel is taken while the sequencer idles, whatever it releases. Each result
// takes 64 reads of the row ring through its single read port, a tail state for
// the read latency and a load of the output register. The next pixel is taken
// only once the last result of the current one sits in the output register.
// The APB port sets frame width and height; any write restarts the frame.
// Reset clears the position counters, empties the output register and loads
// a 640 x 480 frame size; the ring needs no clearing pass. When the receiver
// stalls, the finished result is held in the output register and the
// sequencer waits before loading the next one.
`timescale 1ns / 1ps
module box_mean_filter_8x8 #(
    parameter int MAX_WIDTH  = bmf8_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmf8_pkg::DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_blue, pixel_green, pixel_red
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_blue, out_green, out_red, out_col, out_row, zeros
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bmf8_pkg::*;

    `include "box_mean_filter_8x8_assert.svh"

    logic [CFG_W-1:0] r_frame_width, r_frame_height;
    logic             cfg_wr;
    t_cmd             w_cmd;
    t_sts             w_sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_FRAME_HEIGHT) begin
                r_frame_height <= pwdata[CFG_W-1:0];
            end else begin
                r_frame_width <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_FRAME_WIDTH) ? {21'b0, r_frame_width}
                                                  : {21'b0, r_frame_height};

    bmf8_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .o_s_ready (s_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    bmf8_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cnt_clr      (cfg_wr),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_pixel        (s_tdata),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_m_ready      (m_tready),
        .o_m_valid      (m_tvalid),
        .o_m_data       (m_tdata),
        .o_m_last       (m_tlast)
    );

    // A result is only loaded into a free output register.
    `BMF8_ASSERT_IMP(a_load_free, i_clk, i_rst_n, w_cmd.load_out, w_sts.out_free)
    // Ring reads never overlap a pixel beat.
    `BMF8_ASSERT_IMP(a_no_read_on_accept, i_clk, i_rst_n, s_tvalid && s_tready, !w_cmd.issue)
    // A stalled result beat stays on the bus.
    `BMF8_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid)
endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the streaming 8x8 box mean filter.
`timescale 1ns / 1ps
module tb_top;
    import bmf8_pkg::*;

    localparam int RING_W     = 1024;
    localparam int IDLE_WAIT  = 100;
    localparam int WDOG_LIMIT = 5000;
    localparam int HOLD_LEN   = 800;
    localparam int N_ITEMS    = 280;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [9:0] col;
        logic [9:0] row;
        logic       last_flag;
    } t_mean_px;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // pixel_blue, pixel_green, pixel_red
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // out_blue, out_green, out_red, out_col, out_row, zeros
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    box_mean_filter_8x8 dut (.*);

    // Own copy of the filter state.
    logic [23:0]   ring_mem [0:7][0:RING_W-1];
    int unsigned   col_pos;
    int unsigned   row_pos;
    logic [10:0]   cfg_width;
    logic [10:0]   cfg_height;

    logic [23:0]   pixel_q[$];
    t_mean_px      mean_q[$];
    int            gap_left;
    int            stall_left;
    int            hold_left;
    bit            hold_done;
    int            quiet_cycles;
    int            errors;
    int            pixels_in;
    int            results_out;
    int            frames_sent;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int unsigned clamp_size(logic [10:0] v, int unsigned hi);
        if (v < 11'd8)
            return 8;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned clamp_coord(int v, int unsigned lim);
        if (v < 0)
            return 0;
        if (v >= int'(lim))
            return lim - 1;
        return v;
    endfunction

    function automatic logic [7:0] window_mean(int unsigned sum);
        int unsigned q;
        q = (sum + 1) >> 6;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Stores one pixel and queues every mean that it completes.
    function automatic void take_pixel(logic [23:0] px);
        int unsigned w, h, xlo, xhi, ylo, yhi, yy, xx;
        int unsigned sb, sg, sr;
        t_mean_px    res;
        w = clamp_size(cfg_width, RING_W);
        h = clamp_size(cfg_height, 1024);
        ring_mem[row_pos % 8][col_pos] = px;
        xlo = col_pos - 3;
        xhi = (col_pos == w - 1) ? col_pos : xlo;
        ylo = row_pos - 3;
        yhi = (row_pos == h - 1) ? row_pos : ylo;
        if ((col_pos >= 3 || col_pos == w - 1) && (row_pos >= 3 || row_pos == h - 1)) begin
            for (int unsigned y = ylo; y <= yhi; y++) begin
                for (int unsigned x = xlo; x <= xhi; x++) begin
                    sb = 0;
                    sg = 0;
                    sr = 0;
                    for (int i = -4; i < 4; i++) begin
                        yy = clamp_coord(int'(y) + i, h);
                        for (int j = -4; j < 4; j++) begin
                            xx = clamp_coord(int'(x) + j, w);
                            sb += ring_mem[yy % 8][xx][7:0];
                            sg += ring_mem[yy % 8][xx][15:8];
                            sr += ring_mem[yy % 8][xx][23:16];
                        end
                    end
                    res.blue      = window_mean(sb);
                    res.green     = window_mean(sg);
                    res.red       = window_mean(sr);
                    res.col       = x[9:0];
                    res.row       = y[9:0];
                    res.last_flag = (x == xhi) && (y == yhi);
                    mean_q.push_back(res);
                end
            end
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    // Mostly no gap, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [23:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // Pixel driver; the model is advanced on each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_pixel(s_tdata);
                pixels_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    s_tdata  <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        t_mean_px want;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_out++;
                if (mean_q.size() == 0) begin
                    $error("unexpected result beat col=%0d row=%0d",
                           m_tdata[33:24], m_tdata[43:34]);
                    errors++;
                end else begin
                    want = mean_q.pop_front();
                    if (m_tdata[7:0] !== want.blue) begin
                        $error("out_blue: expected %0d, got %0d", want.blue, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[15:8] !== want.green) begin
                        $error("out_green: expected %0d, got %0d", want.green, m_tdata[15:8]);
                        errors++;
                    end
                    if (m_tdata[23:16] !== want.red) begin
                        $error("out_red: expected %0d, got %0d", want.red, m_tdata[23:16]);
                        errors++;
                    end
                    if (m_tdata[33:24] !== want.col) begin
                        $error("out_col: expected %0d, got %0d", want.col, m_tdata[33:24]);
                        errors++;
                    end
                    if (m_tdata[43:34] !== want.row) begin
                        $error("out_row: expected %0d, got %0d", want.row, m_tdata[43:34]);
                        errors++;
                    end
                    if (m_tlast !== want.last_flag) begin
                        $error("last_in_run: expected %0d, got %0d", want.last_flag, m_tlast);
                        errors++;
                    end
                end
            end
            // One long hold-off part-way through, so the block backs up.
            if (!hold_done && results_out == 30) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready   <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The state is sampled just after the edge, once the driver has settled.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pixel_q.size() != 0 || s_tvalid || mean_q.size() != 0);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    // APB write: setup beat, then access beat; the model follows at the write edge.
    task automatic reg_write(logic reg_idx, logic [10:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {21'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_FRAME_WIDTH)
            cfg_width = value;
        else
            cfg_height = value;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic queue_pixels(int count);
        for (int k = 0; k < count; k++)
            pixel_q.push_back(pick_pixel());
    endtask

    initial begin
        int fw, fh, n;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        col_pos     = 0;
        row_pos     = 0;
        cfg_width   = RST_WIDTH;
        cfg_height  = RST_HEIGHT;
        errors      = 0;
        pixels_in   = 0;
        results_out = 0;
        frames_sent = 0;
        hold_done   = 1'b0;
        quiet_cycles = 0;
        i_rst_n     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset frame size; extreme channel values, no results yet.
        pixel_q = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                    24'hFFFF00, 24'h00FFFF, 24'h010101, 24'hFEFEFE, 24'h80807F,
                    24'h7F8080, 24'hFFFFFF};
        wait_idle();
        // An out-of-range width of 2047 saturates; the height is set to its 1024 maximum.
        reg_write(REG_FRAME_WIDTH, 11'd2047);
        reg_write(REG_FRAME_HEIGHT, 11'd1024);
        queue_pixels(10);
        wait_idle();
        // Undersized values fall back to the 8 x 8 minimum; one whole frame.
        reg_write(REG_FRAME_WIDTH, 11'd0);
        reg_write(REG_FRAME_HEIGHT, 11'd7);
        queue_pixels(64);
        frames_sent++;
        wait_idle();

        while (pixels_in < N_ITEMS) begin
            fw = $urandom_range(8, 12);
            fh = $urandom_range(8, 10);
            if ($urandom_range(0, 7) == 0)
                fw = 1024;
            reg_write(REG_FRAME_WIDTH, fw[10:0]);
            reg_write(REG_FRAME_HEIGHT, fh[10:0]);
            case ($urandom_range(0, 3))
                0: n = $urandom_range(1, fw * 4);           // aborted frame
                1: n = 2 * fw * fh;                         // two frames back to back
                default: n = fw * fh;
            endcase
            if (fw == 1024)
                n = $urandom_range(20, 60);
            if (n > N_ITEMS - pixels_in)
                n = N_ITEMS - pixels_in;
            if (fw != 1024 && n >= fw * fh)
                frames_sent += n / (fw * fh);
            queue_pixels(n);
            wait_idle();
        end

        $display("Streamed %0d pixels over %0d complete frames and several partial ones.",
                 pixels_in, frames_sent);
        $display("Checked %0d filtered results, including one long receiver hold-off.",
                 results_out);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
